FILE: design/bresenham_line_right_half_macros.svh
// Assertion macros for the segment rasterizer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef BRESENHAM_LINE_RIGHT_HALF_MACROS_SVH
`define BRESENHAM_LINE_RIGHT_HALF_MACROS_SVH

// same-cycle implication
`define BLR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BLR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/blr_pkg.sv
// Shared types and constants for the segment rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package blr_pkg;

	localparam int COORD_BITS = 12;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int TW_BITS    = COORD_BITS + 3;
	localparam int ERR_BITS   = COORD_BITS + 4;
	localparam int DIM_BITS   = 12;
	localparam int LINE_BITS  = 14;
	localparam int ADDR_BITS  = 24;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = LINE_BITS;
	localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
	localparam int MUL_BITS   = COORD_BITS + LINE_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [TW_BITS-1:0]    twice_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic signed [DELTA_BITS-1:0] delta_t;

	localparam coord_t COORD_ONE = coord_t'(1);

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [2:0] OCT_SHALLOW_UP   = 3'd0;
	localparam logic [2:0] OCT_STEEP_UP     = 3'd1;
	localparam logic [2:0] OCT_SHALLOW_DOWN = 3'd2;
	localparam logic [2:0] OCT_STEEP_DOWN   = 3'd3;
	localparam logic [2:0] OCT_FLAT         = 3'd4;

	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_BYTES   = 2'd2;

	localparam logic [DIM_BITS-1:0]  RST_IMAGE_WIDTH  = DIM_BITS'(800);
	localparam logic [DIM_BITS-1:0]  RST_IMAGE_HEIGHT = DIM_BITS'(800);
	localparam logic [LINE_BITS-1:0] RST_LINE_BYTES   = LINE_BITS'(3200);

	typedef struct packed {
		logic   vld;
		coord_t x;
		coord_t y;
		logic   last;
	} pix_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]  image_width;
		logic [DIM_BITS-1:0]  image_height;
		logic [LINE_BITS-1:0] line_bytes;
	} cfg_t;

endpackage

`default_nettype wire

FILE: design/blr_walker.sv
// Segment setup and Bresenham stepper with the first pipeline register.
// Depends on blr_pkg.
`default_nettype none

module blr_walker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic           mode,
	input  blr_pkg::coord_t x_start,
	input  blr_pkg::coord_t y_start,
	input  blr_pkg::coord_t x_end,
	input  blr_pkg::coord_t y_end,
	input  logic           advance,
	output blr_pkg::pix_t  pix_s1
);
	import blr_pkg::*;

	coord_t     cur_x_q, cur_y_q, end_x_q, end_y_q;
	twice_t     twice_dx_q, twice_dy_q;
	err_t       err_q;
	logic [2:0] oct_q;
	logic       active_q;

	delta_t     dx, dy;
	err_t       dxe, dye, ndye;
	logic [2:0] ld_oct;
	err_t       ld_err;
	logic       ld_active;

	coord_t     nx, ny;
	err_t       e1, ne;
	logic       fin;

	logic       vld_s1;
	coord_t     x_s1, y_s1;
	logic       last_s1;

	always_comb begin
		dx   = delta_t'(x_end) - delta_t'(x_start);
		dy   = delta_t'(y_end) - delta_t'(y_start);
		dxe  = err_t'(dx);
		dye  = err_t'(dy);
		ndye = -dye;
		ld_active = !(dx[DELTA_BITS-1] || (dx == '0 && dy == '0));
		if (dy == '0) begin
			ld_oct = OCT_FLAT;
			ld_err = '0;
		end else if (!dy[DELTA_BITS-1]) begin
			ld_oct = (dxe >= dye) ? OCT_SHALLOW_UP : OCT_STEEP_UP;
			ld_err = (dxe >= dye) ? dxe : dye;
		end else begin
			ld_oct = (dxe >= ndye) ? OCT_SHALLOW_DOWN : OCT_STEEP_DOWN;
			ld_err = (dxe >= ndye) ? dxe : dye;
		end
	end

	always_comb begin
		nx  = cur_x_q;
		ny  = cur_y_q;
		e1  = err_q;
		ne  = err_q;
		fin = 1'b0;
		unique case (oct_q)
			OCT_SHALLOW_UP: begin
				nx = cur_x_q + COORD_ONE;
				e1 = err_q - err_t'(twice_dy_q);
				ne = e1;
				if (e1[ERR_BITS-1]) begin
					ny = cur_y_q + COORD_ONE;
					ne = e1 + err_t'(twice_dx_q);
				end
				fin = (nx == end_x_q);
			end
			OCT_STEEP_UP: begin
				ny = cur_y_q + COORD_ONE;
				e1 = err_q - err_t'(twice_dx_q);
				ne = e1;
				if (e1[ERR_BITS-1]) begin
					nx = cur_x_q + COORD_ONE;
					ne = e1 + err_t'(twice_dy_q);
				end
				fin = (ny == end_y_q);
			end
			OCT_SHALLOW_DOWN: begin
				nx = cur_x_q + COORD_ONE;
				e1 = err_q + err_t'(twice_dy_q);
				ne = e1;
				if (e1[ERR_BITS-1]) begin
					ny = cur_y_q - COORD_ONE;
					ne = e1 + err_t'(twice_dx_q);
				end
				fin = (nx == end_x_q);
			end
			OCT_STEEP_DOWN: begin
				ny = cur_y_q - COORD_ONE;
				e1 = err_q + err_t'(twice_dx_q);
				ne = e1;
				if (!e1[ERR_BITS-1] && (e1 != '0)) begin
					nx = cur_x_q + COORD_ONE;
					ne = e1 + err_t'(twice_dy_q);
				end
				fin = (ny == end_y_q);
			end
			default: begin
				nx  = cur_x_q + COORD_ONE;
				fin = (nx == end_x_q);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			end_x_q    <= '0;
			end_y_q    <= '0;
			twice_dx_q <= '0;
			twice_dy_q <= '0;
			err_q      <= '0;
			oct_q      <= OCT_SHALLOW_UP;
			active_q   <= 1'b0;
		end else if (take) begin
			if (mode == MODE_LOAD) begin
				cur_x_q    <= x_start;
				cur_y_q    <= y_start;
				end_x_q    <= x_end;
				end_y_q    <= y_end;
				twice_dx_q <= twice_t'(dx) <<< 1;
				twice_dy_q <= twice_t'(dy) <<< 1;
				err_q      <= ld_active ? ld_err : '0;
				oct_q      <= ld_active ? ld_oct : OCT_FLAT;
				active_q   <= ld_active;
			end else if (active_q) begin
				cur_x_q  <= nx;
				cur_y_q  <= ny;
				err_q    <= ne;
				active_q <= !fin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= (mode == MODE_TICK) && active_q;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && mode == MODE_TICK && active_q) begin
			x_s1    <= cur_x_q;
			y_s1    <= cur_y_q;
			last_s1 <= fin;
		end
	end

	assign pix_s1 = '{vld: vld_s1, x: x_s1, y: y_s1, last: last_s1};

endmodule

`default_nettype wire

FILE: design/blr_addr.sv
// Clip test and frame buffer address, held in the output register.
// Depends on blr_pkg.
`default_nettype none

module blr_addr (
	input  logic                           clk,
	input  logic                           arst_n,
	input  blr_pkg::pix_t                  pix_s1,
	input  blr_pkg::cfg_t                  cfg,
	input  logic                           out_stall,
	output logic                           advance,
	output logic                           out_valid,
	output blr_pkg::coord_t                pixel_x,
	output blr_pkg::coord_t                pixel_y,
	output logic [blr_pkg::ADDR_BITS-1:0]  byte_address,
	output logic                           visible,
	output logic                           last
);
	import blr_pkg::*;

	logic                 vis;
	logic [MUL_BITS-1:0]  prod;
	logic [ADDR_BITS-1:0] addr;

	logic                 vld_s2;
	coord_t               x_s2, y_s2;
	logic [ADDR_BITS-1:0] addr_s2;
	logic                 vis_s2;
	logic                 last_s2;

	always_comb begin
		vis = !pix_s1.x[COORD_BITS-1] && !pix_s1.y[COORD_BITS-1] &&
		      (CMP_BITS'($unsigned(pix_s1.x)) < CMP_BITS'(cfg.image_width)) &&
		      (CMP_BITS'($unsigned(pix_s1.y)) < CMP_BITS'(cfg.image_height));
		prod = MUL_BITS'($unsigned(pix_s1.y)) * MUL_BITS'(cfg.line_bytes);
		addr = ADDR_BITS'(prod) + ADDR_BITS'({$unsigned(pix_s1.x), 2'b00});
	end

	assign advance = !vld_s2 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= pix_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pix_s1.vld) begin
			x_s2    <= pix_s1.x;
			y_s2    <= pix_s1.y;
			addr_s2 <= vis ? addr : '0;
			vis_s2  <= vis;
			last_s2 <= pix_s1.last;
		end
	end

	assign out_valid    = vld_s2;
	assign pixel_x      = x_s2;
	assign pixel_y      = y_s2;
	assign byte_address = addr_s2;
	assign visible      = vis_s2;
	assign last         = last_s2;

endmodule

`default_nettype wire

FILE: design/bresenham_line_right_half.sv
// Bresenham rasterizer for rightward segments, one pixel per clock per tick
// transaction while in_stall is low, through the walker's register and the
// output register. The walker's per-pixel step (one error add and one
// correction add) is combinational; the address multiply sits in the output
// stage. A load transaction gives no pixel; a tick while idle gives none either.
// Configuration writes are taken at once and must arrive while idle.
`default_nettype none
`include "bresenham_line_right_half_macros.svh"

module bresenham_line_right_half (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               mode,
	input  blr_pkg::coord_t                    x_start,
	input  blr_pkg::coord_t                    y_start,
	input  blr_pkg::coord_t                    x_end,
	input  blr_pkg::coord_t                    y_end,
	output logic                               out_valid,
	input  logic                               out_stall,
	output blr_pkg::coord_t                    pixel_x,
	output blr_pkg::coord_t                    pixel_y,
	output logic [blr_pkg::ADDR_BITS-1:0]      byte_address,
	output logic                               visible,
	output logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [blr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [blr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import blr_pkg::*;

	cfg_t cfg_q;
	pix_t pix_s1;
	logic advance;
	logic take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= RST_IMAGE_WIDTH;
			cfg_q.image_height <= RST_IMAGE_HEIGHT;
			cfg_q.line_bytes   <= RST_LINE_BYTES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[DIM_BITS-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[DIM_BITS-1:0];
				REG_LINE_BYTES:   cfg_q.line_bytes   <= cfg_data[LINE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = pix_s1.vld && !advance;
	assign take     = in_valid && !in_stall;

	blr_walker u_walker (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.mode    (mode),
		.x_start (x_start),
		.y_start (y_start),
		.x_end   (x_end),
		.y_end   (y_end),
		.advance (advance),
		.pix_s1  (pix_s1)
	);

	blr_addr u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_s1       (pix_s1),
		.cfg          (cfg_q),
		.out_stall    (out_stall),
		.advance      (advance),
		.out_valid    (out_valid),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.byte_address (byte_address),
		.visible      (visible),
		.last         (last)
	);

	`BLR_ASSERT_IMP(a_stall_full, in_stall, out_valid && out_stall && pix_s1.vld, "stall without full pipe")
	`BLR_ASSERT_NXT(a_load_silent, take && mode == MODE_LOAD, !pix_s1.vld, "load produced a pixel")
	`BLR_ASSERT_IMP(a_vis_addr, out_valid && !visible, byte_address == '0, "clipped pixel has address")
	`BLR_ASSERT_IMP(a_vis_coord, out_valid && visible, !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1], "visible pixel negative")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the rightward segment rasterizer (bresenham_line_right_half).
// Needs blr_pkg and the block's RTL. A queue-fed driver, a pixel monitor and an
// in-bench raster predictor check every pixel across several register settings.
`default_nettype none

module testbench;
	import blr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int GAP_PERCENT  = 23;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic   mode;
		coord_t xs;
		coord_t ys;
		coord_t xe;
		coord_t ye;
	} seg_cmd_t;

	typedef struct {
		coord_t                x;
		coord_t                y;
		logic [ADDR_BITS-1:0]  addr;
		logic                  vis;
		logic                  last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = MODE_LOAD;
	coord_t x_start = '0;
	coord_t y_start = '0;
	coord_t x_end = '0;
	coord_t y_end = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	coord_t pixel_x;
	coord_t pixel_y;
	logic [ADDR_BITS-1:0] byte_address;
	logic visible;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	bresenham_line_right_half dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .mode(mode),
		.x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .byte_address(byte_address),
		.visible(visible), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	seg_cmd_t pending_cmds[$];
	pixel_t   expected_pixels[$];
	seg_cmd_t cur_cmd;
	logic     gaps_on = 1'b1;
	int       cmds_queued = 0;
	int       cmds_taken = 0;
	int       loads_taken = 0;
	int       ticks_taken = 0;
	int       pixels_checked = 0;
	int       cfg_writes = 0;
	int       errors = 0;
	int       cycle_count = 0;

	// raster predictor state and register copies
	int         clip_w = 800;
	int         clip_h = 800;
	int         row_bytes = 3200;
	int         walk_x = 0;
	int         walk_y = 0;
	int         stop_x = 0;
	int         stop_y = 0;
	int         step2_x = 0;
	int         step2_y = 0;
	int         err_acc = 0;
	logic [2:0] octant = OCT_SHALLOW_UP;
	logic       drawing = 1'b0;

	task automatic rasterize(input seg_cmd_t c);
		int     dx;
		int     dy;
		int     px;
		int     py;
		logic   done;
		pixel_t p;
		if (c.mode == MODE_LOAD) begin
			walk_x = int'(c.xs);
			walk_y = int'(c.ys);
			stop_x = int'(c.xe);
			stop_y = int'(c.ye);
			dx = stop_x - walk_x;
			dy = stop_y - walk_y;
			step2_x = 2 * dx;
			step2_y = 2 * dy;
			drawing = 1'b1;
			if (dx < 0 || (dx == 0 && dy == 0)) begin
				drawing = 1'b0;
				octant = OCT_FLAT;
				err_acc = 0;
			end else if (dy == 0) begin
				octant = OCT_FLAT;
				err_acc = 0;
			end else if (dy > 0) begin
				octant = (dx >= dy) ? OCT_SHALLOW_UP : OCT_STEEP_UP;
				err_acc = (dx >= dy) ? dx : dy;
			end else begin
				octant = (dx >= -dy) ? OCT_SHALLOW_DOWN : OCT_STEEP_DOWN;
				err_acc = (dx >= -dy) ? dx : dy;
			end
		end else if (drawing) begin
			px = walk_x;
			py = walk_y;
			p.vis = px >= 0 && py >= 0 && px < clip_w && py < clip_h;
			p.addr = p.vis ? ADDR_BITS'(py * row_bytes + px * 4) : '0;
			case (octant)
				OCT_SHALLOW_UP: begin
					walk_x++;
					err_acc -= step2_y;
					if (err_acc < 0) begin
						walk_y++;
						err_acc += step2_x;
					end
					done = walk_x == stop_x;
				end
				OCT_STEEP_UP: begin
					walk_y++;
					err_acc -= step2_x;
					if (err_acc < 0) begin
						walk_x++;
						err_acc += step2_y;
					end
					done = walk_y == stop_y;
				end
				OCT_SHALLOW_DOWN: begin
					walk_x++;
					err_acc += step2_y;
					if (err_acc < 0) begin
						walk_y--;
						err_acc += step2_x;
					end
					done = walk_x == stop_x;
				end
				OCT_STEEP_DOWN: begin
					walk_y--;
					err_acc += step2_x;
					if (err_acc > 0) begin
						walk_x++;
						err_acc += step2_y;
					end
					done = walk_y == stop_y;
				end
				default: begin
					walk_x++;
					done = walk_x >= stop_x;
				end
			endcase
			if (done)
				drawing = 1'b0;
			p.x = coord_t'(px);
			p.y = coord_t'(py);
			p.last = done;
			expected_pixels.push_back(p);
		end
	endtask

	// driver: hold a transaction until taken, then advance or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				rasterize(cur_cmd);
				cmds_taken++;
				if (cur_cmd.mode == MODE_LOAD)
					loads_taken++;
				else
					ticks_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_cmds.size() > 0 &&
				    !(gaps_on && $urandom_range(99) < GAP_PERCENT)) begin
					cur_cmd = pending_cmds.pop_front();
					in_valid <= 1'b1;
					mode <= cur_cmd.mode;
					x_start <= cur_cmd.xs;
					y_start <= cur_cmd.ys;
					x_end <= cur_cmd.xe;
					y_end <= cur_cmd.ye;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each pixel transaction with the oldest prediction
	always @(posedge clk) begin
		pixel_t p;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected pixel x=%0d y=%0d", pixel_x, pixel_y);
					errors++;
				end else begin
					p = expected_pixels.pop_front();
					pixels_checked++;
					if (pixel_x !== p.x) begin
						$error("pixel_x expected %0d got %0d", p.x, pixel_x);
						errors++;
					end
					if (pixel_y !== p.y) begin
						$error("pixel_y expected %0d got %0d", p.y, pixel_y);
						errors++;
					end
					if (byte_address !== p.addr) begin
						$error("byte_address expected %0d got %0d", p.addr, byte_address);
						errors++;
					end
					if (visible !== p.vis) begin
						$error("visible expected %0d got %0d", p.vis, visible);
						errors++;
					end
					if (last !== p.last) begin
						$error("last expected %0d got %0d", p.last, last);
						errors++;
					end
				end
			end
			out_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("run timed out with %0d pixels outstanding", expected_pixels.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic queue_cmd(input logic m, input int xs, input int ys, input int xe,
	                         input int ye);
		seg_cmd_t c;
		c.mode = m;
		c.xs = coord_t'(xs);
		c.ys = coord_t'(ys);
		c.xe = coord_t'(xe);
		c.ye = coord_t'(ye);
		pending_cmds.push_back(c);
		cmds_queued++;
	endtask

	task automatic queue_segment(input int xs, input int ys, input int xe, input int ye,
	                             input int ticks);
		queue_cmd(MODE_LOAD, xs, ys, xe, ye);
		repeat (ticks)
			queue_cmd(MODE_TICK, $urandom, $urandom, $urandom, $urandom);
	endtask

	function automatic int seg_len(input int xs, input int ys, input int xe, input int ye);
		int dx;
		int ady;
		dx = xe - xs;
		ady = (ye > ys) ? ye - ys : ys - ye;
		if (dx < 0)
			return 0;
		return (dx >= ady) ? dx : ady;
	endfunction

	task automatic random_segment(input int span);
		int dx;
		int dy;
		int xs;
		int ys;
		int lo;
		int hi;
		int n;
		int sel;
		dx = $urandom_range(span);
		dy = $urandom_range(2 * span) - span;
		if ($urandom_range(1)) begin
			xs = $urandom_range(120) - 20;
			ys = $urandom_range(120) - 20;
		end else begin
			xs = -2048 + $urandom_range(4095 - dx);
			lo = (dy < 0) ? -2048 - dy : -2048;
			hi = (dy > 0) ? 2047 - dy : 2047;
			ys = lo + $urandom_range(hi - lo);
		end
		n = seg_len(xs, ys, xs + dx, ys + dy);
		sel = $urandom_range(9);
		if (sel == 0)
			n = $urandom_range(n);
		else if (sel == 1)
			n = n + $urandom_range(3, 1);
		queue_segment(xs, ys, xs + dx, ys + dy, n);
	endtask

	task automatic random_traffic(input int count);
		int goal;
		int sel;
		int xs;
		int ys;
		goal = cmds_queued + count;
		while (cmds_queued < goal) begin
			sel = $urandom_range(99);
			if (sel < 70) begin
				random_segment(12);
			end else if (sel < 78) begin
				random_segment(60);
			end else if (sel < 80) begin
				random_segment(300);
			end else if (sel < 88) begin
				xs = $urandom_range(4095) - 2047;
				ys = $urandom_range(4095) - 2048;
				if ($urandom_range(1))
					queue_segment(xs, ys, xs, ys, $urandom_range(2, 1));
				else
					queue_segment(xs, ys, -2048 + $urandom_range(xs + 2047),
					              $urandom_range(4095) - 2048, $urandom_range(2, 1));
			end else begin
				queue_cmd(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
			end
		end
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
		case (idx)
			REG_IMAGE_WIDTH:  clip_w = int'(data[DIM_BITS-1:0]);
			REG_IMAGE_HEIGHT: clip_h = int'(data[DIM_BITS-1:0]);
			REG_LINE_BYTES:   row_bytes = int'(data[LINE_BITS-1:0]);
			default: ;
		endcase
	endtask

	task automatic set_image(input int w, input int h, input int lb);
		cfg_write(REG_IMAGE_WIDTH, CFG_DATA_BITS'(w));
		cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(h));
		cfg_write(REG_LINE_BYTES, CFG_DATA_BITS'(lb));
	endtask

	task automatic drain();
		while (cmds_taken != cmds_queued || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_cmd(MODE_TICK, 0, 0, 0, 0);
		queue_segment(0, 0, 3, 1, 3);
		queue_segment(10, 10, 11, 12, 2);
		queue_segment(20, 20, 22, 19, 2);
		queue_segment(30, 30, 31, 28, 2);
		queue_segment(797, 799, 801, 799, 4);
		queue_segment(5, 5, 4, 9, 1);
		queue_segment(7, 7, 7, 7, 1);
		queue_segment(-2048, -2048, 2047, 2047, 2);
		queue_segment(2047, 2047, 2047, -2048, 1);
		random_traffic(150);
		drain();

		set_image(1, 1, 4);
		random_traffic(150);
		drain();

		@(posedge clk);
		gaps_on <= 1'b0;
		set_image(4095, 4095, 16383);
		random_traffic(150);
		drain();
		@(posedge clk);
		gaps_on <= 1'b1;

		set_image(2048, 2048, 8192);
		cfg_write(REG_UNUSED, CFG_DATA_BITS'($urandom));
		random_traffic(150);
		drain();

		set_image($urandom_range(2048, 1), $urandom_range(2048, 1), $urandom_range(8192, 4));
		random_traffic(150);
		drain();

		$display("Run covered %0d transactions: %0d segment loads and %0d ticks,",
		         cmds_taken, loads_taken, ticks_taken);
		$display("%0d pixels checked across %0d register writes.", pixels_checked, cfg_writes);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
+incdir+design
design/blr_pkg.sv
design/blr_walker.sv
design/blr_addr.sv
design/bresenham_line_right_half.sv
bench/testbench.sv
